/* hw/rtl/tlpd_pkg.sv */
`timescale 1ns / 1ps

package tlpd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_LONG_TOUCH    = 2'd1;
    localparam logic [1:0] CFG_INIT_TIMEOUT  = 2'd2;

    localparam int CFG_WIDTH = 16;

    // Register values after reset
    localparam logic [CFG_WIDTH-1:0] POLL_INTERVAL_RESET = 16'd100;
    localparam logic [CFG_WIDTH-1:0] LONG_TOUCH_RESET    = 16'd3000;
    localparam logic [CFG_WIDTH-1:0] INIT_TIMEOUT_RESET  = 16'd2500;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_READY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CLS_RESET   = 2'd0,
        CLS_TOUCH   = 2'd1,
        CLS_NOTOUCH = 2'd2,
        CLS_ATIERR  = 2'd3
    } class_t;

    typedef struct packed {
        logic start_req;
        logic read_ok;
        logic status_noise;
        logic cal_running;
        logic cal_error;
        logic pad_touch;
    } item_t;

    typedef struct packed {
        logic       long_touch_event;
        logic [1:0] touch_class;
        logic [1:0] phase;
        logic       init_done;
        logic       init_timed_out;
    } result_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] poll_interval_ms;
        logic [CFG_WIDTH-1:0] long_touch_ms;
        logic [CFG_WIDTH-1:0] init_timeout_ms;
    } cfg_t;

endpackage

/* hw/rtl/touch_long_press_detector_core.sv */
`timescale 1ns / 1ps
// Path: an item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while result_ready keeps the result slot free;
// the tracker state updates in a single pass.
// Reset: rst_n clears all timers, phase, class and valid bits at once and loads
// the register defaults (poll 100, hold 3000, timeout 2500).

module touch_long_press_detector_core #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tlpd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output tlpd_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata
);
    import tlpd_pkg::*;

    logic    stage_valid;
    item_t   stage_item;
    logic    advance;
    result_t step_result;
    cfg_t    cfg_reg;
    logic    result_valid_reg;
    result_t result_reg;

    // Move the held item through when the result slot is free
    assign advance = stage_valid && (!result_valid_reg || result_ready);

    tlpd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    tlpd_tracker #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval_ms <= POLL_INTERVAL_RESET;
            cfg_reg.long_touch_ms    <= LONG_TOUCH_RESET;
            cfg_reg.init_timeout_ms  <= INIT_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLL_INTERVAL: cfg_reg.poll_interval_ms <= cfg_wdata;
                CFG_LONG_TOUCH:    cfg_reg.long_touch_ms    <= cfg_wdata;
                CFG_INIT_TIMEOUT:  cfg_reg.init_timeout_ms  <= cfg_wdata;
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Hold result valid until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* hw/rtl/tlpd_in_stage.sv */
`timescale 1ns / 1ps

module tlpd_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  tlpd_pkg::item_t item,
    input  logic            advance,
    output logic            stage_valid,
    output tlpd_pkg::item_t stage_item
);
    import tlpd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new transfer when empty or when the held item moves on
    assign item_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
        begin
            valid_next = item_valid;
        end
    end

    // Hold the control bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on every accepted transfer
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

/* hw/rtl/tlpd_tracker.sv */
`timescale 1ns / 1ps

module tlpd_tracker #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  tlpd_pkg::item_t   item,
    input  tlpd_pkg::cfg_t    cfg,
    output tlpd_pkg::result_t result
);
    import tlpd_pkg::*;

    // Compare width covers both the timers and the 16-bit registers
    localparam int CW = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

    phase_t                 phase_reg, phase_next;
    class_t                 class_reg, class_next;
    logic                   long_reported_reg, long_reported_next;
    logic [TIMER_WIDTH-1:0] since_start_reg, since_start_next;
    logic [TIMER_WIDTH-1:0] since_poll_reg, since_poll_next;
    logic [TIMER_WIDTH-1:0] press_reg, press_next;

    logic [TIMER_WIDTH-1:0] since_start_inc, since_poll_inc, press_inc;
    logic [CW-1:0]          start_cmp, poll_cmp, press_cmp;
    logic [CW-1:0]          timeout_cmp, interval_cmp, hold_cmp;
    logic                   calib_clean;
    logic                   done, timed_out, poll;
    logic                   event_fire;
    class_t                 polled_class;

    // Saturating elapsed-tick counters
    assign since_start_inc = (since_start_reg == '1) ? since_start_reg : since_start_reg + 1'b1;
    assign since_poll_inc  = (since_poll_reg == '1) ? since_poll_reg : since_poll_reg + 1'b1;
    assign press_inc       = (press_reg == '1) ? press_reg : press_reg + 1'b1;

    assign start_cmp    = CW'(since_start_inc);
    assign poll_cmp     = CW'(since_poll_inc);
    assign press_cmp    = CW'(press_inc);
    assign timeout_cmp  = CW'(cfg.init_timeout_ms);
    assign interval_cmp = CW'(cfg.poll_interval_ms);
    assign hold_cmp     = CW'(cfg.long_touch_ms);

    assign calib_clean = item.read_ok && !item.status_noise && !item.cal_running;

    // Next phase, wait exit and poll timing
    always_comb
    begin
        phase_next       = phase_reg;
        since_start_next = since_start_inc;
        since_poll_next  = since_poll_inc;
        done             = 1'b0;
        timed_out        = 1'b0;
        poll             = 1'b0;
        if (item.start_req)
        begin
            phase_next       = PH_WAIT;
            since_start_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (calib_clean)
                    begin
                        done = 1'b1;
                    end
                    else if (start_cmp > timeout_cmp)
                    begin
                        done      = 1'b1;
                        timed_out = 1'b1;
                    end
                    if (done)
                    begin
                        phase_next      = PH_READY;
                        since_poll_next = '0;
                    end
                end
                PH_READY:
                begin
                    if (poll_cmp >= interval_cmp)
                    begin
                        poll            = 1'b1;
                        since_poll_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Classify the poll and track the hold
    always_comb
    begin
        if (!item.read_ok)
        begin
            polled_class = class_reg;
        end
        else if (item.cal_error)
        begin
            polled_class = CLS_ATIERR;
        end
        else if (item.pad_touch)
        begin
            polled_class = CLS_TOUCH;
        end
        else
        begin
            polled_class = CLS_NOTOUCH;
        end

        class_next         = class_reg;
        long_reported_next = long_reported_reg;
        press_next         = press_inc;
        event_fire         = 1'b0;
        if (poll)
        begin
            class_next = polled_class;
            case (class_reg)
                CLS_RESET, CLS_NOTOUCH:
                begin
                    if (polled_class == CLS_TOUCH)
                    begin
                        press_next = '0;
                    end
                end
                CLS_TOUCH:
                begin
                    if (polled_class == CLS_TOUCH)
                    begin
                        if (press_cmp >= hold_cmp && !long_reported_reg)
                        begin
                            long_reported_next = 1'b1;
                            event_fire         = 1'b1;
                        end
                    end
                    else if (polled_class == CLS_NOTOUCH)
                    begin
                        long_reported_next = 1'b0;
                    end
                end
                default:
                begin
                    press_next = press_inc;
                end
            endcase
        end
    end

    // Drive the result of this tick
    always_comb
    begin
        result.long_touch_event = event_fire;
        result.touch_class      = class_next;
        result.phase            = phase_next;
        result.init_done        = done;
        result.init_timed_out   = timed_out;
    end

    // Advance the state once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            class_reg         <= CLS_RESET;
            long_reported_reg <= 1'b0;
            since_start_reg   <= '0;
            since_poll_reg    <= '0;
            press_reg         <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            class_reg         <= class_next;
            long_reported_reg <= long_reported_next;
            since_start_reg   <= since_start_next;
            since_poll_reg    <= since_poll_next;
            press_reg         <= press_next;
        end
    end

endmodule
